// ===== rtl/core/wsel_pkg.sv =====
// Shared types and constants for the weekly alarm selector.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
package wsel_pkg;

   // Entry count and field widths.
   localparam int ENTRIES     = 7;
   localparam int IDX_W       = 3;
   localparam int HOUR_W      = 5;
   localparam int MINUTE_W    = 6;
   localparam int SECOND_W    = 6;
   localparam int WEEKDAY_W   = 3;
   localparam int MELODY_W    = 8;
   localparam int ENTRY_W     = 22;
   localparam int TIME_W      = 11;

   // Markers for "no alarm selected".
   localparam logic [IDX_W-1:0]    NONE_INDEX  = 3'd7;
   localparam logic [HOUR_W-1:0]   NONE_HOUR   = 5'd25;
   localparam logic [MINUTE_W-1:0] NONE_MINUTE = 6'd61;
   localparam logic [MELODY_W-1:0] NONE_MELODY = 8'd0;

   // Search limits in minutes of the day.
   localparam logic [TIME_W-1:0] NONE_TIME   = 11'(25 * 60 + 61);
   localparam logic [TIME_W-1:0] DAY_MINUTES = 11'(24 * 60);

   // Alarm modes; the codes above one-shot count as off.
   localparam logic [2:0] MODE_OFF      = 3'd0;
   localparam logic [2:0] MODE_DAILY    = 3'd1;
   localparam logic [2:0] MODE_WEEKDAYS = 3'd2;
   localparam logic [2:0] MODE_WEEKENDS = 3'd3;
   localparam logic [2:0] MODE_ONESHOT  = 3'd4;

   // Commands.
   localparam logic CMD_SELECT = 1'b0;
   localparam logic CMD_CHECK  = 1'b1;

   // Weekday codes that bound the weekend tests.
   localparam logic [WEEKDAY_W-1:0] WD_SUNDAY   = 3'd1;
   localparam logic [WEEKDAY_W-1:0] WD_FRIDAY   = 3'd6;
   localparam logic [WEEKDAY_W-1:0] WD_SATURDAY = 3'd7;

   // Search record handed from cell to cell.
   typedef struct packed {
      logic                valid;
      logic [TIME_W-1:0]   cur;
      logic                we_today;
      logic                we_tom;
      logic                today_found;
      logic [TIME_W-1:0]   today_time;
      logic [IDX_W-1:0]    today_idx;
      logic [HOUR_W-1:0]   today_hour;
      logic [MINUTE_W-1:0] today_minute;
      logic [MELODY_W-1:0] today_melody;
      logic                tom_found;
      logic [TIME_W-1:0]   tom_time;
      logic [IDX_W-1:0]    tom_idx;
      logic [HOUR_W-1:0]   tom_hour;
      logic [MINUTE_W-1:0] tom_minute;
      logic [MELODY_W-1:0] tom_melody;
   } search_type;

   // Minutes of the day from hour and minute: hour * 60 as two shifts.
   function automatic logic [TIME_W-1:0] day_time(input logic [HOUR_W-1:0] hour,
                                                  input logic [MINUTE_W-1:0] minute);
      logic [TIME_W-1:0] h;
      h = TIME_W'(hour);
      return (h << 6) - (h << 2) + TIME_W'(minute);
   endfunction

endpackage

// ===== rtl/core/wsel_if.sv =====
// Channel interfaces of the weekly alarm selector: request word and response word.
// Depends on wsel_pkg for field widths.
interface wsel_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 cmd;
   logic [wsel_pkg::HOUR_W-1:0]          now_hour;
   logic [wsel_pkg::MINUTE_W-1:0]        now_minute;
   logic [wsel_pkg::SECOND_W-1:0]        now_second;
   logic [wsel_pkg::WEEKDAY_W-1:0]       now_weekday;

   modport source (output valid, cmd, now_hour, now_minute, now_second, now_weekday,
                   input ready);
   modport sink   (input valid, cmd, now_hour, now_minute, now_second, now_weekday,
                   output ready);
endinterface

interface wsel_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [wsel_pkg::IDX_W-1:0]           chosen_index;
   logic [wsel_pkg::HOUR_W-1:0]          chosen_hour;
   logic [wsel_pkg::MINUTE_W-1:0]        chosen_minute;
   logic [wsel_pkg::MELODY_W-1:0]        chosen_melody;
   logic                                 alarm_found;
   logic                                 main_fired;
   logic                                 hourly_fired;

   modport source (output valid, chosen_index, chosen_hour, chosen_minute, chosen_melody,
                   alarm_found, main_fired, hourly_fired, input ready);
   modport sink   (input valid, chosen_index, chosen_hour, chosen_minute, chosen_melody,
                   alarm_found, main_fired, hourly_fired, output ready);
endinterface

// ===== rtl/core/wsel_cell.sv =====
// One alarm cell: holds one entry register and its spent bit, and updates the
// search record passing through it. Depends on wsel_pkg.
module wsel_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [wsel_pkg::IDX_W-1:0]    cell_index,
   input  logic                          wr_en,
   input  logic [wsel_pkg::ENTRY_W-1:0]  wr_data,
   input  logic                          spent_set,
   input  wsel_pkg::search_type          rec_in,
   output wsel_pkg::search_type          rec_out,
   output logic                          is_oneshot
);

   logic [wsel_pkg::ENTRY_W-1:0]  entry_ff;
   logic                          spent_ff;
   wsel_pkg::search_type          rec_ff;
   wsel_pkg::search_type          rec_in_next;

   logic [2:0]                        mode;
   logic [wsel_pkg::HOUR_W-1:0]       hour;
   logic [wsel_pkg::MINUTE_W-1:0]     minute;
   logic [wsel_pkg::MELODY_W-1:0]     melody;
   logic [wsel_pkg::TIME_W-1:0]       t;
   logic                              q_today;
   logic                              q_tom;
   logic                              today_hit;
   logic                              tom_hit;

   // Unpack the entry.
   assign mode   = entry_ff[2:0];
   assign hour   = entry_ff[7:3];
   assign minute = entry_ff[13:8];
   assign melody = entry_ff[21:14];
   assign t      = wsel_pkg::day_time(hour, minute);
   assign is_oneshot = (mode == wsel_pkg::MODE_ONESHOT);

   // A spent one-shot counts as off; weekday and weekend modes follow the day.
   always_comb begin
      if (mode == wsel_pkg::MODE_ONESHOT) begin
         q_today = !spent_ff;
         q_tom   = !spent_ff;
      end else begin
         q_today = (mode == wsel_pkg::MODE_DAILY) ||
                   (mode == wsel_pkg::MODE_WEEKDAYS && !rec_in.we_today) ||
                   (mode == wsel_pkg::MODE_WEEKENDS && rec_in.we_today);
         q_tom   = (mode == wsel_pkg::MODE_DAILY) ||
                   (mode == wsel_pkg::MODE_WEEKDAYS && !rec_in.we_tom) ||
                   (mode == wsel_pkg::MODE_WEEKENDS && rec_in.we_tom);
      end
   end

   // Today: later than now and not later than the best so far, so the higher index
   // wins a tie. Tomorrow: strictly earliest, so the lower index wins a tie.
   assign today_hit = q_today && (t > rec_in.cur) && (t <= rec_in.today_time);
   assign tom_hit   = q_tom && (t < rec_in.tom_time);

   always_comb begin
      rec_in_next = rec_in;
      if (today_hit) begin
         rec_in_next.today_found  = 1'b1;
         rec_in_next.today_time   = t;
         rec_in_next.today_idx    = cell_index;
         rec_in_next.today_hour   = hour;
         rec_in_next.today_minute = minute;
         rec_in_next.today_melody = melody;
      end
      if (tom_hit) begin
         rec_in_next.tom_found  = 1'b1;
         rec_in_next.tom_time   = t;
         rec_in_next.tom_idx    = cell_index;
         rec_in_next.tom_hour   = hour;
         rec_in_next.tom_minute = minute;
         rec_in_next.tom_melody = melody;
      end
   end

   // Entry register and spent bit; rewriting the entry keeps the spent bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         spent_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            entry_ff <= wr_data;
         end
         if (spent_set) begin
            spent_ff <= 1'b1;
         end
      end
   end

   // Record stage toward the next cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff.valid <= 1'b0;
      end else begin
         rec_ff <= rec_in_next;
      end
   end

   assign rec_out = rec_ff;

endmodule

// ===== rtl/core/weekly_alarm_selector.sv =====
// Top level of the weekly alarm selector: control, held selection and the cell chain.
// Depends on wsel_pkg, wsel_if.sv (wsel_req_if, wsel_rsp_if) and wsel_cell.
//
//  Channel   Direction  Contents
//  req_if    in         cmd, now_hour, now_minute, now_second, now_weekday
//  rsp_if    out        chosen_index/hour/minute/melody, alarm_found, main_fired, hourly_fired
//  csr_*     in         write enable, register index 0..6, 22-bit entry
//
// A select response is valid once the search record has passed the seven cells, one per cycle
// from the accepting edge on, has been latched as the search result and has been loaded into
// the output register; a check word goes straight to the done state and loads it from there.
// The load waits until the previous response is taken. One word is in work at a time, yet a
// new word is taken while the previous response still waits in the output register.
// Reset is synchronous: it clears the entries, the spent bits and the held selection.
module weekly_alarm_selector (
   input  logic                             clock,
   input  logic                             reset,
   wsel_req_if.sink                         req_if,
   wsel_rsp_if.source                       rsp_if,
   input  logic                             csr_wr_en,
   input  logic [wsel_pkg::IDX_W-1:0]       csr_index,
   input  logic [wsel_pkg::ENTRY_W-1:0]     csr_wr_data
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_DONE   = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // Latched request word.
   logic                               cmd_ff;
   logic [wsel_pkg::HOUR_W-1:0]        hour_ff;
   logic [wsel_pkg::MINUTE_W-1:0]      minute_ff;
   logic [wsel_pkg::SECOND_W-1:0]      second_ff;

   // Held selection.
   logic [wsel_pkg::IDX_W-1:0]         sel_index_ff,  sel_index_in;
   logic [wsel_pkg::HOUR_W-1:0]        sel_hour_ff,   sel_hour_in;
   logic [wsel_pkg::MINUTE_W-1:0]      sel_minute_ff, sel_minute_in;
   logic [wsel_pkg::MELODY_W-1:0]      sel_melody_ff, sel_melody_in;

   // Output register.
   logic                               rsp_valid_ff;
   logic                               rsp_main_ff,   rsp_main_in;
   logic                               rsp_hourly_ff, rsp_hourly_in;

   wsel_pkg::search_type               chain [wsel_pkg::ENTRIES+1];
   wsel_pkg::search_type               launch_rec;
   wsel_pkg::search_type               res_ff;
   logic [wsel_pkg::ENTRIES:0]         oneshot_vec;
   logic [wsel_pkg::ENTRIES-1:0]       spent_set;

   logic accept;
   logic finish;
   logic main_hit;
   logic we_today;
   logic we_tom;

   assign accept       = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE);
   assign finish       = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_if.ready);

   // Launch record for a select word.
   assign we_today = (req_if.now_weekday > wsel_pkg::WD_FRIDAY) ||
                     (req_if.now_weekday < 3'(wsel_pkg::WD_SUNDAY + 3'd1));
   assign we_tom   = (req_if.now_weekday == wsel_pkg::WD_FRIDAY) ||
                     (req_if.now_weekday == wsel_pkg::WD_SATURDAY);

   always_comb begin
      launch_rec              = '0;
      launch_rec.valid        = accept && (req_if.cmd == wsel_pkg::CMD_SELECT);
      launch_rec.cur          = wsel_pkg::day_time(req_if.now_hour, req_if.now_minute);
      launch_rec.we_today     = we_today;
      launch_rec.we_tom       = we_tom;
      launch_rec.today_time   = wsel_pkg::NONE_TIME;
      launch_rec.tom_time     = wsel_pkg::DAY_MINUTES;
   end

   assign chain[0] = launch_rec;

   // Row of alarm cells.
   assign oneshot_vec[wsel_pkg::ENTRIES] = 1'b0;
   for (genvar g = 0; g < wsel_pkg::ENTRIES; g++) begin : g_cell
      wsel_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (wsel_pkg::IDX_W'(g)),
         .wr_en      (csr_wr_en && (csr_index == wsel_pkg::IDX_W'(g))),
         .wr_data    (csr_wr_data),
         .spent_set  (spent_set[g]),
         .rec_in     (chain[g]),
         .rec_out    (chain[g+1]),
         .is_oneshot (oneshot_vec[g])
      );
   end

   // Main alarm match against the held selection.
   assign main_hit = (sel_index_ff != wsel_pkg::NONE_INDEX) &&
                     (hour_ff == sel_hour_ff) && (minute_ff == sel_minute_ff) &&
                     (second_ff == '0);

   // Mark the held one-shot entry spent when it fires.
   always_comb begin
      spent_set = '0;
      if (finish && cmd_ff == wsel_pkg::CMD_CHECK && main_hit &&
          oneshot_vec[sel_index_ff]) begin
         for (int i = 0; i < wsel_pkg::ENTRIES; i++) begin
            spent_set[i] = (sel_index_ff == wsel_pkg::IDX_W'(i));
         end
      end
   end

   // Next selection and response flags.
   always_comb begin
      sel_index_in  = sel_index_ff;
      sel_hour_in   = sel_hour_ff;
      sel_minute_in = sel_minute_ff;
      sel_melody_in = sel_melody_ff;
      rsp_main_in   = 1'b0;
      rsp_hourly_in = 1'b0;
      if (cmd_ff == wsel_pkg::CMD_SELECT) begin
         if (res_ff.today_found) begin
            sel_index_in  = res_ff.today_idx;
            sel_hour_in   = res_ff.today_hour;
            sel_minute_in = res_ff.today_minute;
            sel_melody_in = res_ff.today_melody;
         end else if (res_ff.tom_found && res_ff.tom_time < res_ff.cur) begin
            sel_index_in  = res_ff.tom_idx;
            sel_hour_in   = res_ff.tom_hour;
            sel_minute_in = res_ff.tom_minute;
            sel_melody_in = res_ff.tom_melody;
         end else begin
            sel_index_in  = wsel_pkg::NONE_INDEX;
            sel_hour_in   = wsel_pkg::NONE_HOUR;
            sel_minute_in = wsel_pkg::NONE_MINUTE;
            sel_melody_in = wsel_pkg::NONE_MELODY;
         end
      end else begin
         rsp_main_in   = main_hit;
         rsp_hourly_in = (minute_ff == '0) && (second_ff == '0);
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_if.cmd == wsel_pkg::CMD_SELECT) ? ST_SEARCH : ST_DONE;
            end
         end
         ST_SEARCH: begin
            if (chain[wsel_pkg::ENTRIES].valid) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         sel_index_ff  <= wsel_pkg::NONE_INDEX;
         sel_hour_ff   <= wsel_pkg::NONE_HOUR;
         sel_minute_ff <= wsel_pkg::NONE_MINUTE;
         sel_melody_ff <= wsel_pkg::NONE_MELODY;
      end else begin
         state_ff <= state_in;
         if (finish) begin
            rsp_valid_ff  <= 1'b1;
            sel_index_ff  <= sel_index_in;
            sel_hour_ff   <= sel_hour_in;
            sel_minute_ff <= sel_minute_in;
            sel_melody_ff <= sel_melody_in;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Request word, search result and response flags.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= req_if.cmd;
         hour_ff   <= req_if.now_hour;
         minute_ff <= req_if.now_minute;
         second_ff <= req_if.now_second;
      end
      if (chain[wsel_pkg::ENTRIES].valid) begin
         res_ff <= chain[wsel_pkg::ENTRIES];
      end
      if (finish) begin
         rsp_main_ff   <= rsp_main_in;
         rsp_hourly_ff <= rsp_hourly_in;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.chosen_index  = sel_index_ff;
   assign rsp_if.chosen_hour   = sel_hour_ff;
   assign rsp_if.chosen_minute = sel_minute_ff;
   assign rsp_if.chosen_melody = sel_melody_ff;
   assign rsp_if.alarm_found   = (sel_index_ff != wsel_pkg::NONE_INDEX);
   assign rsp_if.main_fired    = rsp_main_ff;
   assign rsp_if.hourly_fired  = rsp_hourly_ff;

   // The record leaves the chain only while a select word is in search.
   a_tail_in_search: assert property (@(posedge clock) disable iff (reset)
      chain[wsel_pkg::ENTRIES].valid |-> (state_ff == ST_SEARCH))
      else $error("search record left the chain outside a search");

   // At most one entry is marked spent, and only on a firing check.
   a_spent_onehot: assert property (@(posedge clock) disable iff (reset)
      (spent_set != '0) |-> ($onehot(spent_set) && rsp_main_in))
      else $error("spent marking without a single firing entry");

   // A fired main alarm always refers to a held selection.
   a_main_has_sel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_main_ff) |-> (sel_index_ff != wsel_pkg::NONE_INDEX))
      else $error("main alarm fired with no selection held");

   // The held selection only moves when a response word is loaded.
   a_sel_stable: assert property (@(posedge clock) disable iff (reset)
      !$past(finish) |-> $stable(sel_index_ff))
      else $error("selection changed without a finished word");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Testbench for the weekly alarm selector: directed and random select and check words,
// checked word by word against a predictor kept in this file.
// Depends on rtl/core/wsel_pkg.sv, rtl/core/wsel_if.sv and rtl/core/weekly_alarm_selector.sv.
module tb;

   localparam int          SETTLE_CYCLES = 12;
   localparam int          HOLD_CYCLES   = 120;
   localparam int unsigned TIMEOUT_NS    = 1_000_000;

   // Register index past the last entry; writes to it must change nothing.
   localparam logic [wsel_pkg::IDX_W-1:0] CSR_SPARE = wsel_pkg::IDX_W'(wsel_pkg::ENTRIES);

   // Mode codes above one-shot, all of which mean off.
   localparam logic [2:0] MODE_RSVD_LO  = 3'd5;
   localparam logic [2:0] MODE_RSVD_MID = 3'd6;
   localparam logic [2:0] MODE_RSVD_HI  = 3'd7;

   typedef struct packed {
      logic                           cmd;
      logic [wsel_pkg::HOUR_W-1:0]    hour;
      logic [wsel_pkg::MINUTE_W-1:0]  minute;
      logic [wsel_pkg::SECOND_W-1:0]  second;
      logic [wsel_pkg::WEEKDAY_W-1:0] weekday;
   } time_word_type;

   typedef struct packed {
      logic [wsel_pkg::IDX_W-1:0]    chosen_index;
      logic [wsel_pkg::HOUR_W-1:0]   chosen_hour;
      logic [wsel_pkg::MINUTE_W-1:0] chosen_minute;
      logic [wsel_pkg::MELODY_W-1:0] chosen_melody;
      logic                          alarm_found;
      logic                          main_fired;
      logic                          hourly_fired;
   } alarm_result_type;

   logic clock = 1'b0;
   logic reset;
   logic                          csr_wr_en;
   logic [wsel_pkg::IDX_W-1:0]    csr_index;
   logic [wsel_pkg::ENTRY_W-1:0]  csr_wr_data;

   wsel_req_if req_ch ();
   wsel_rsp_if rsp_ch ();

   weekly_alarm_selector i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor state: the entries as written, the held selection and the spent one-shots.
   logic [wsel_pkg::ENTRY_W-1:0]  alarm_regs [wsel_pkg::ENTRIES];
   logic [wsel_pkg::ENTRY_W-1:0]  staged_alarms [wsel_pkg::ENTRIES];
   logic [wsel_pkg::IDX_W-1:0]    held_index;
   logic [wsel_pkg::HOUR_W-1:0]   held_hour;
   logic [wsel_pkg::MINUTE_W-1:0] held_minute;
   logic [wsel_pkg::MELODY_W-1:0] held_melody;
   logic [wsel_pkg::ENTRIES-1:0]  spent_bits;

   alarm_result_type expected_results [$];
   alarm_result_type want;

   bit sender_gaps;
   bit rsp_stalls;
   bit rsp_hold_request;
   int mismatches;
   int select_count;
   int check_count;
   int fire_count;
   int hourly_count;
   int load_count;

   function automatic logic [wsel_pkg::ENTRY_W-1:0] alarm_word(
         input logic [2:0] mode,
         input logic [wsel_pkg::HOUR_W-1:0] hour,
         input logic [wsel_pkg::MINUTE_W-1:0] minute,
         input logic [wsel_pkg::MELODY_W-1:0] melody);
      return {melody, minute, hour, mode};
   endfunction

   function automatic void drop_selection();
      held_index  = wsel_pkg::NONE_INDEX;
      held_hour   = wsel_pkg::NONE_HOUR;
      held_minute = wsel_pkg::NONE_MINUTE;
      held_melody = wsel_pkg::NONE_MELODY;
   endfunction

   function automatic void hold_entry(input int i);
      held_index  = wsel_pkg::IDX_W'(i);
      held_hour   = alarm_regs[i][7:3];
      held_minute = alarm_regs[i][13:8];
      held_melody = alarm_regs[i][21:14];
   endfunction

   // A spent one-shot counts as off; reserved mode codes never qualify.
   function automatic bit entry_active(input int i, input bit weekend);
      logic [2:0] mode;
      mode = alarm_regs[i][2:0];
      if (mode == wsel_pkg::MODE_ONESHOT)
         return !spent_bits[i];
      return (mode == wsel_pkg::MODE_DAILY) ||
             (mode == wsel_pkg::MODE_WEEKDAYS && !weekend) ||
             (mode == wsel_pkg::MODE_WEEKENDS && weekend);
   endfunction

   // Works out the response to one word and updates the held selection and spent bits.
   function automatic alarm_result_type predict_result(input time_word_type w);
      alarm_result_type r;
      int  now_min, best_today, best_tom, t, tom_idx;
      bit  today_found, we_today, we_tom;
      r = '0;
      if (w.cmd == wsel_pkg::CMD_SELECT) begin
         now_min     = int'(w.hour) * 60 + int'(w.minute);
         best_today  = int'(wsel_pkg::NONE_TIME);
         best_tom    = int'(wsel_pkg::DAY_MINUTES);
         tom_idx     = wsel_pkg::ENTRIES;
         today_found = 1'b0;
         // Weekday 0 falls out as weekend today and weekday tomorrow.
         we_today = (w.weekday == wsel_pkg::WD_SATURDAY) || (w.weekday <= wsel_pkg::WD_SUNDAY);
         we_tom   = (w.weekday >= wsel_pkg::WD_FRIDAY);
         drop_selection();
         for (int i = 0; i < wsel_pkg::ENTRIES; i++) begin
            t = int'(alarm_regs[i][7:3]) * 60 + int'(alarm_regs[i][13:8]);
            // Nearest time still ahead today; on a tie the higher entry wins.
            if (entry_active(i, we_today) && t > now_min && t <= best_today) begin
               hold_entry(i);
               best_today  = t;
               today_found = 1'b1;
            end
            // Earliest time tomorrow; on a tie the lower entry wins.
            if (entry_active(i, we_tom) && t < best_tom) begin
               best_tom = t;
               tom_idx  = i;
            end
         end
         if (!today_found && tom_idx < wsel_pkg::ENTRIES && best_tom < now_min)
            hold_entry(tom_idx);
         select_count++;
      end else begin
         if (held_index != wsel_pkg::NONE_INDEX && w.hour == held_hour &&
             w.minute == held_minute && w.second == '0) begin
            r.main_fired = 1'b1;
            fire_count++;
            if (alarm_regs[held_index][2:0] == wsel_pkg::MODE_ONESHOT)
               spent_bits[held_index] = 1'b1;
         end
         r.hourly_fired = (w.minute == '0 && w.second == '0);
         if (r.hourly_fired)
            hourly_count++;
         check_count++;
      end
      r.chosen_index  = held_index;
      r.chosen_hour   = held_hour;
      r.chosen_minute = held_minute;
      r.chosen_melody = held_melody;
      r.alarm_found   = (held_index != wsel_pkg::NONE_INDEX);
      return r;
   endfunction

   // Most gaps are zero or short, a few are long.
   function automatic int pick_gap(input bit enabled);
      int r;
      if (!enabled)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [wsel_pkg::ENTRY_W-1:0] random_entry();
      logic [2:0]                    mode;
      logic [wsel_pkg::HOUR_W-1:0]   hour;
      logic [wsel_pkg::MINUTE_W-1:0] minute;
      int                            r;
      r = $urandom_range(0, 9);
      if (r == 0)
         mode = wsel_pkg::MODE_OFF;
      else if (r < 3)
         mode = wsel_pkg::MODE_DAILY;
      else if (r < 5)
         mode = wsel_pkg::MODE_WEEKDAYS;
      else if (r < 7)
         mode = wsel_pkg::MODE_WEEKENDS;
      else if (r < 9)
         mode = wsel_pkg::MODE_ONESHOT;
      else
         mode = 3'($urandom_range(int'(MODE_RSVD_LO), int'(MODE_RSVD_HI)));
      // A small pool of times makes ties between entries common.
      r = $urandom_range(0, 9);
      if (r < 3) begin
         hour   = wsel_pkg::HOUR_W'($urandom_range(6, 7));
         minute = $urandom_range(0, 1) ? 6'd30 : 6'd0;
      end else if (r == 9) begin
         hour   = wsel_pkg::HOUR_W'($urandom_range(0, 31));
         minute = wsel_pkg::MINUTE_W'($urandom_range(0, 63));
      end else begin
         hour   = wsel_pkg::HOUR_W'($urandom_range(0, 23));
         minute = wsel_pkg::MINUTE_W'($urandom_range(0, 59));
      end
      return alarm_word(mode, hour, minute, wsel_pkg::MELODY_W'($urandom_range(0, 255)));
   endfunction

   // Offers one word after a random gap and waits until the block takes it.
   task automatic send_word(input logic cmd, input logic [wsel_pkg::HOUR_W-1:0] hour,
                            input logic [wsel_pkg::MINUTE_W-1:0] minute,
                            input logic [wsel_pkg::SECOND_W-1:0] second,
                            input logic [wsel_pkg::WEEKDAY_W-1:0] weekday);
      time_word_type w;
      int            gap;
      w.cmd     = cmd;
      w.hour    = hour;
      w.minute  = minute;
      w.second  = second;
      w.weekday = weekday;
      gap = pick_gap(sender_gaps);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.cmd         <= cmd;
      req_ch.now_hour    <= hour;
      req_ch.now_minute  <= minute;
      req_ch.now_second  <= second;
      req_ch.now_weekday <= weekday;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      expected_results.push_back(predict_result(w));
   endtask

   // Stops offering words and waits until every response has come back.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_alarm(input logic [wsel_pkg::IDX_W-1:0] index,
                              input logic [wsel_pkg::ENTRY_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= data;
      if (index < wsel_pkg::IDX_W'(wsel_pkg::ENTRIES))
         alarm_regs[index] = data;
      @(posedge clock);
   endtask

   // Writes all staged entries once the block is idle, plus a write to the spare index.
   task automatic load_alarms();
      drain();
      for (int i = 0; i < wsel_pkg::ENTRIES; i++)
         write_alarm(wsel_pkg::IDX_W'(i), staged_alarms[i]);
      write_alarm(CSR_SPARE, wsel_pkg::ENTRY_W'($urandom));
      csr_wr_en <= 1'b0;
      @(posedge clock);
      load_count++;
   endtask

   // After reset: no selection held, all entries off.
   task automatic test_idle_state();
      send_word(wsel_pkg::CMD_CHECK, wsel_pkg::NONE_HOUR, wsel_pkg::NONE_MINUTE, 6'd0,
                wsel_pkg::WD_SUNDAY);
      send_word(wsel_pkg::CMD_CHECK, 5'd0, 6'd0, 6'd0, 3'd0);
      send_word(wsel_pkg::CMD_SELECT, 5'd12, 6'd0, 6'd0, 3'd4);
   endtask

   // Every mode code but off, both ties, weekend edges and the next-day fallback.
   task automatic test_modes_and_days();
      staged_alarms[0] = alarm_word(wsel_pkg::MODE_DAILY,    5'd7,  6'd30, 8'd255);
      staged_alarms[1] = alarm_word(wsel_pkg::MODE_WEEKDAYS, 5'd7,  6'd30, 8'd1);
      staged_alarms[2] = alarm_word(wsel_pkg::MODE_WEEKENDS, 5'd9,  6'd15, 8'd2);
      staged_alarms[3] = alarm_word(wsel_pkg::MODE_ONESHOT,  5'd23, 6'd59, 8'd3);
      staged_alarms[4] = alarm_word(MODE_RSVD_LO,            5'd6,  6'd0,  8'd4);
      staged_alarms[5] = alarm_word(MODE_RSVD_MID,           5'd5,  6'd0,  8'd5);
      staged_alarms[6] = alarm_word(MODE_RSVD_HI,            5'd31, 6'd63, 8'd170);
      load_alarms();
      send_word(wsel_pkg::CMD_SELECT, 5'd6,  6'd0,  6'd0,  3'd2);
      send_word(wsel_pkg::CMD_SELECT, 5'd6,  6'd0,  6'd0,  wsel_pkg::WD_SUNDAY);
      send_word(wsel_pkg::CMD_SELECT, 5'd7,  6'd30, 6'd0,  wsel_pkg::WD_SATURDAY);
      send_word(wsel_pkg::CMD_SELECT, 5'd23, 6'd59, 6'd59, 3'd3);
      send_word(wsel_pkg::CMD_SELECT, 5'd0,  6'd0,  6'd0,  3'd0);
      send_word(wsel_pkg::CMD_SELECT, 5'd31, 6'd63, 6'd63, wsel_pkg::WD_FRIDAY);
      send_word(wsel_pkg::CMD_CHECK,  5'd7,  6'd30, 6'd0,  wsel_pkg::WD_FRIDAY);
      send_word(wsel_pkg::CMD_CHECK,  5'd7,  6'd30, 6'd63, wsel_pkg::WD_FRIDAY);
   endtask

   // A one-shot fires, becomes spent and stays spent across a rewrite.
   task automatic test_one_shot();
      send_word(wsel_pkg::CMD_SELECT, 5'd23, 6'd0,  6'd0, 3'd4);
      send_word(wsel_pkg::CMD_CHECK,  5'd23, 6'd59, 6'd0, 3'd4);
      send_word(wsel_pkg::CMD_CHECK,  5'd23, 6'd59, 6'd0, 3'd4);
      send_word(wsel_pkg::CMD_SELECT, 5'd23, 6'd0,  6'd0, 3'd4);
      load_alarms();
      send_word(wsel_pkg::CMD_SELECT, 5'd23, 6'd0,  6'd0, 3'd4);
   endtask

   // An alarm at exactly the current minute is never chosen.
   task automatic test_exact_minute();
      foreach (staged_alarms[i])
         staged_alarms[i] = '0;
      staged_alarms[0] = alarm_word(wsel_pkg::MODE_DAILY, 5'd8, 6'd0, 8'd9);
      load_alarms();
      send_word(wsel_pkg::CMD_SELECT, 5'd8, 6'd0, 6'd0, 3'd2);
      send_word(wsel_pkg::CMD_SELECT, 5'd8, 6'd1, 6'd0, 3'd2);
      send_word(wsel_pkg::CMD_CHECK,  5'd8, 6'd0, 6'd0, 3'd2);
      send_word(wsel_pkg::CMD_CHECK,  5'd9, 6'd0, 6'd0, 3'd2);
      send_word(wsel_pkg::CMD_SELECT, 5'd9, 6'd0, 6'd0, 3'd2);
   endtask

   // The receiver holds off while words keep coming, so the block must stall its input.
   task automatic test_backpressure();
      sender_gaps      = 1'b0;
      rsp_hold_request = 1'b1;
      for (int i = 0; i < 24; i++)
         send_word(i[0] ? wsel_pkg::CMD_CHECK : wsel_pkg::CMD_SELECT,
                   wsel_pkg::HOUR_W'($urandom_range(0, 23)),
                   wsel_pkg::MINUTE_W'($urandom_range(0, 59)), 6'd0,
                   wsel_pkg::WEEKDAY_W'($urandom_range(1, 7)));
      drain();
      sender_gaps = 1'b1;
   endtask

   // One select followed by checks aimed at the held time and the top of the hour,
   // or now and then a word with every field random.
   task automatic run_random_day(inout int sent);
      int                             r;
      int                             j;
      logic [wsel_pkg::HOUR_W-1:0]    hour;
      logic [wsel_pkg::MINUTE_W-1:0]  minute;
      logic [wsel_pkg::WEEKDAY_W-1:0] wd;
      r = $urandom_range(0, 99);
      if (r >= 85) begin
         send_word(1'($urandom_range(0, 1)), wsel_pkg::HOUR_W'($urandom_range(0, 31)),
                   wsel_pkg::MINUTE_W'($urandom_range(0, 63)),
                   wsel_pkg::SECOND_W'($urandom_range(0, 63)),
                   wsel_pkg::WEEKDAY_W'($urandom_range(0, 7)));
         sent++;
         return;
      end
      j      = $urandom_range(0, wsel_pkg::ENTRIES - 1);
      hour   = alarm_regs[j][7:3];
      minute = alarm_regs[j][13:8];
      r      = $urandom_range(0, 3);
      if (r == 1) begin
         minute = minute + 6'd1;
      end else if (r == 2) begin
         hour   = wsel_pkg::HOUR_W'($urandom_range(0, 23));
         minute = wsel_pkg::MINUTE_W'($urandom_range(0, 59));
      end else if (r == 3) begin
         hour   = wsel_pkg::HOUR_W'($urandom_range(0, 31));
         minute = wsel_pkg::MINUTE_W'($urandom_range(0, 63));
      end
      wd = wsel_pkg::WEEKDAY_W'($urandom_range(0, 7));
      send_word(wsel_pkg::CMD_SELECT, hour, minute,
                wsel_pkg::SECOND_W'($urandom_range(0, 59)), wd);
      sent++;
      repeat ($urandom_range(1, 4)) begin
         r = $urandom_range(0, 9);
         if (r < 5)
            send_word(wsel_pkg::CMD_CHECK, held_hour, held_minute, 6'd0, wd);
         else if (r < 7)
            send_word(wsel_pkg::CMD_CHECK, wsel_pkg::HOUR_W'($urandom_range(0, 23)),
                      6'd0, 6'd0, wd);
         else if (r < 8)
            send_word(wsel_pkg::CMD_CHECK, held_hour, held_minute,
                      wsel_pkg::SECOND_W'($urandom_range(1, 63)), wd);
         else
            send_word(wsel_pkg::CMD_CHECK, wsel_pkg::HOUR_W'($urandom_range(0, 23)),
                      wsel_pkg::MINUTE_W'($urandom_range(0, 59)),
                      wsel_pkg::SECOND_W'($urandom_range(0, 59)), wd);
         sent++;
      end
      // Selecting again at the same time shows whether a one-shot just got spent.
      if ($urandom_range(0, 3) == 0) begin
         send_word(wsel_pkg::CMD_SELECT, hour, minute, 6'd0, wd);
         sent++;
      end
   endtask

   // Phases of random traffic over several alarm settings, the extremes first.
   task automatic test_random_days();
      int sent;
      int target;
      for (int p = 0; p < 8; p++) begin
         sender_gaps = (p % 3 != 0);
         rsp_stalls  = (p % 4 != 1);
         for (int i = 0; i < wsel_pkg::ENTRIES; i++) begin
            if (p == 0)
               staged_alarms[i] = '1;
            else if (p == 1)
               staged_alarms[i] = '0;
            else
               staged_alarms[i] = random_entry();
            if (p == 2)
               staged_alarms[i][2:0] = wsel_pkg::MODE_ONESHOT;
         end
         load_alarms();
         sent   = 0;
         target = (p < 2) ? 30 : 120;
         while (sent < target)
            run_random_day(sent);
      end
      sender_gaps = 1'b1;
      rsp_stalls  = 1'b1;
   endtask

   task automatic compare_field(input string field, input logic [7:0] exp_v,
                                input logic [7:0] got_v);
      if (got_v !== exp_v) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, field, exp_v, got_v);
         mismatches++;
      end
   endtask

   // Each response word is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_results.size() == 0) begin
            $display("%0t ns: response word with no prediction waiting, index %0d",
                     $time, rsp_ch.chosen_index);
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            compare_field("chosen_index",  8'(want.chosen_index),  8'(rsp_ch.chosen_index));
            compare_field("chosen_hour",   8'(want.chosen_hour),   8'(rsp_ch.chosen_hour));
            compare_field("chosen_minute", 8'(want.chosen_minute), 8'(rsp_ch.chosen_minute));
            compare_field("chosen_melody", want.chosen_melody,     rsp_ch.chosen_melody);
            compare_field("alarm_found",   8'(want.alarm_found),   8'(rsp_ch.alarm_found));
            compare_field("main_fired",    8'(want.main_fired),    8'(rsp_ch.main_fired));
            compare_field("hourly_fired",  8'(want.hourly_fired),  8'(rsp_ch.hourly_fired));
         end
      end
   end

   // Response side pacing: random stalls, plus one long hold-off on request.
   initial begin : rsp_pacing
      int stall_left;
      int hold_left;
      stall_left   = 0;
      hold_left    = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request) begin
            hold_left        = HOLD_CYCLES;
            rsp_hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall_left = pick_gap(rsp_stalls);
         end
      end
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("simulation failed");
      $finish;
   end

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.cmd         = wsel_pkg::CMD_SELECT;
      req_ch.now_hour    = '0;
      req_ch.now_minute  = '0;
      req_ch.now_second  = '0;
      req_ch.now_weekday = '0;
      csr_wr_en          = 1'b0;
      csr_index          = '0;
      csr_wr_data        = '0;
      foreach (alarm_regs[i])
         alarm_regs[i] = '0;
      drop_selection();
      spent_bits       = '0;
      sender_gaps      = 1'b1;
      rsp_stalls       = 1'b1;
      rsp_hold_request = 1'b0;
      mismatches       = 0;
      select_count     = 0;
      check_count      = 0;
      fire_count       = 0;
      hourly_count     = 0;
      load_count       = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_idle_state();
      test_modes_and_days();
      test_one_shot();
      test_exact_minute();
      test_backpressure();
      test_random_days();
      drain();

      $display("Covered %0d select and %0d check words over %0d alarm settings.",
               select_count, check_count, load_count);
      $display("Main alarm fired %0d times, hourly alarm %0d times; spent one-shots %b.",
               fire_count, hourly_count, spent_bits);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== weekly_alarm_selector.f =====
rtl/core/wsel_pkg.sv
rtl/core/wsel_if.sv
rtl/core/wsel_cell.sv
rtl/core/weekly_alarm_selector.sv
dv/tb.sv
